FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/vgd_pkg.sv
// ----------------------------------------------------------------------------
// vgd_pkg
// Types, sizes and codes shared by the voxel grid downsampler.
// ----------------------------------------------------------------------------
package vgd_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 24;
  localparam int COL_W      = 8;
  localparam int SUM_W      = COORD_W + IDX_W;
  localparam int DVS_W      = 16;
  localparam int MINP_W     = 13;
  localparam int KEY_W      = 3 * COORD_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);

  localparam logic [DVS_W-1:0] LEAF_RESET = 16'd102;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MINP = 1'b1;

  // divider operand axis
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [COL_W-1:0]          red;
    logic [COL_W-1:0]          green;
  } in_item_t;

  typedef struct packed {
    logic                      valid_res;
    logic signed [COORD_W-1:0] cent_x;
    logic signed [COORD_W-1:0] cent_y;
    logic signed [COORD_W-1:0] cent_z;
    logic [COL_W-1:0]          red_max;
    logic [COL_W-1:0]          green_max;
    logic                      last_voxel;
    logic                      dropped;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [COL_W-1:0]          red;
    logic [COL_W-1:0]          green;
  } pt_t;

  localparam int PT_W = $bits(pt_t);

  // controller to datapath
  typedef struct packed {
    logic       push_wr;
    logic       ovf_set;
    logic       clr_store;
    logic       idx_clr;
    logic       idx_inc;
    logic       key_wr;
    logic       acc_clr;
    logic       acc_en;
    logic       bound_clr;
    logic       bound_strict;
    logic       bound_incl;
    logic       res_cap;
    logic       div_start;
    logic       div_cent;
    logic [1:0] div_axis;
    logic       out_fire;
    logic       out_valid;
    logic       out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic idx_end;
    logic found;
    logic qual;
    logic div_done;
  } sts_t;

endpackage

FILE: sv/vgd_ram.sv
// ----------------------------------------------------------------------------
// vgd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/vgd_div.sv
// ----------------------------------------------------------------------------
// vgd_div
// Radix-2 restoring divider, signed dividend over unsigned divisor, floor.
// ----------------------------------------------------------------------------
module vgd_div import vgd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dvd,
  input  logic [DVS_W-1:0]        dvs,
  output logic                    done,
  output logic signed [SUM_W-1:0] quo
);

  logic              busy_r, done_r, neg_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  mag_r;
  logic [DVS_W:0]    rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  mag_in;

  assign mag_in = dvd[SUM_W-1] ? (~dvd + 1'b1) : dvd;
  assign rem_sh = {rem_r[DVS_W-1:0], mag_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      neg_r  <= dvd[SUM_W-1];
      mag_r  <= mag_in;
      rem_r  <= '0;
      dvs_r  <= dvs;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      mag_r  <= {mag_r[SUM_W-2:0], ge};
      rem_r  <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    end
  end

  // round towards minus infinity: -q - 1 is ~q
  assign quo  = !neg_r ? mag_r : ((rem_r != '0) ? ~mag_r : (~mag_r + 1'b1));
  assign done = done_r;

endmodule

FILE: sv/vgd_dp.sv
// ----------------------------------------------------------------------------
// vgd_dp
// Datapath: point and cell-key stores, scan accumulators, divider, result.
// ----------------------------------------------------------------------------
module vgd_dp import vgd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  in_item_t          in_item,
  input  logic [DVS_W-1:0]  leaf_size,
  input  logic [MINP_W-1:0] min_points,
  output logic              out_strobe,
  output out_item_t         out_item
);

  logic [CNT_W-1:0] count_r, idx_r;
  logic             ovf_r;
  pt_t              pt_wr, pt_rd;
  logic [KEY_W-1:0] key_wr, key_rd;

  logic signed [COORD_W-1:0] cell_x_r, cell_y_r, cell_z_r;
  logic signed [COORD_W-1:0] cent_x_r, cent_y_r, cent_z_r;
  logic signed [SUM_W-1:0]   sx_r, sy_r, sz_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [COL_W-1:0]          rmax_r, gmax_r, res_red_r, res_green_r;
  logic [KEY_W-1:0]          best_r, bound_r;
  logic                      found_r, bound_en_r, strict_r;

  logic                    dsel_cent_r;
  logic [1:0]              dsel_axis_r;
  logic signed [SUM_W-1:0] dvd, quo;
  logic [DVS_W-1:0]        dvs, leaf_eff;
  logic                    div_done;
  logic signed [COORD_W-1:0] crd;
  logic signed [SUM_W-1:0]   sum_sel;
  logic                      elig;

  out_item_t out_r;
  logic      strobe_r;

  assign pt_wr = '{pos_x: in_item.pos_x, pos_y: in_item.pos_y, pos_z: in_item.pos_z,
                   red: in_item.red, green: in_item.green};

  vgd_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk  (clk),
    .we   (cmd.push_wr),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(pt_wr),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(pt_rd)
  );

  // sign bits flipped so that cell order is plain unsigned order, z major
  assign key_wr = {~cell_z_r[COORD_W-1], cell_z_r[COORD_W-2:0],
                   ~cell_y_r[COORD_W-1], cell_y_r[COORD_W-2:0],
                   ~cell_x_r[COORD_W-1], cell_x_r[COORD_W-2:0]};

  vgd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_POINTS)) u_key_ram (
    .clk  (clk),
    .we   (cmd.key_wr),
    .waddr(idx_r[IDX_W-1:0]),
    .wdata(key_wr),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(key_rd)
  );

  // divider operands
  assign leaf_eff = (leaf_size == '0) ? DVS_W'(1) : leaf_size;

  always_comb begin
    case (cmd.div_axis)
      AX_Y:    begin crd = pt_rd.pos_y; sum_sel = sy_r; end
      AX_Z:    begin crd = pt_rd.pos_z; sum_sel = sz_r; end
      default: begin crd = pt_rd.pos_x; sum_sel = sx_r; end
    endcase
  end

  assign dvd = cmd.div_cent ? sum_sel : {{(SUM_W-COORD_W){crd[COORD_W-1]}}, crd};
  assign dvs = cmd.div_cent ? {{(DVS_W-CNT_W){1'b0}}, cnt_r} : leaf_eff;

  vgd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .dvd  (dvd),
    .dvs  (dvs),
    .done (div_done),
    .quo  (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_cent_r <= cmd.div_cent;
      dsel_axis_r <= cmd.div_axis;
    end
    if (div_done) begin
      case ({dsel_cent_r, dsel_axis_r})
        {1'b0, AX_X}: cell_x_r <= quo[COORD_W-1:0];
        {1'b0, AX_Y}: cell_y_r <= quo[COORD_W-1:0];
        {1'b0, AX_Z}: cell_z_r <= quo[COORD_W-1:0];
        {1'b1, AX_X}: cent_x_r <= quo[COORD_W-1:0];
        {1'b1, AX_Y}: cent_y_r <= quo[COORD_W-1:0];
        {1'b1, AX_Z}: cent_z_r <= quo[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // store bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      bound_en_r <= 1'b0;
      found_r    <= 1'b0;
      idx_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      if (cmd.clr_store) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (cmd.push_wr) count_r <= count_r + 1'b1;
        if (cmd.ovf_set) ovf_r   <= 1'b1;
      end
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.clr_store || cmd.bound_clr)        bound_en_r <= 1'b0;
      else if (cmd.bound_strict || cmd.bound_incl) bound_en_r <= 1'b1;
      if (cmd.acc_clr) begin
        found_r <= 1'b0;
      end else if (cmd.acc_en && elig) begin
        found_r <= 1'b1;
      end
      strobe_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bound_strict || cmd.bound_incl) begin
      bound_r  <= best_r;
      strict_r <= cmd.bound_strict;
    end
  end

  // scan: track the smallest eligible cell and fold its points in
  assign elig = !bound_en_r || (key_rd > bound_r) || (!strict_r && key_rd == bound_r);

  always_ff @(posedge clk) begin
    if (cmd.acc_en && elig) begin
      if (!found_r || key_rd < best_r) begin
        best_r <= key_rd;
        sx_r   <= {{(SUM_W-COORD_W){pt_rd.pos_x[COORD_W-1]}}, pt_rd.pos_x};
        sy_r   <= {{(SUM_W-COORD_W){pt_rd.pos_y[COORD_W-1]}}, pt_rd.pos_y};
        sz_r   <= {{(SUM_W-COORD_W){pt_rd.pos_z[COORD_W-1]}}, pt_rd.pos_z};
        cnt_r  <= CNT_W'(1);
        rmax_r <= pt_rd.red;
        gmax_r <= pt_rd.green;
      end else if (key_rd == best_r) begin
        sx_r   <= sx_r + {{(SUM_W-COORD_W){pt_rd.pos_x[COORD_W-1]}}, pt_rd.pos_x};
        sy_r   <= sy_r + {{(SUM_W-COORD_W){pt_rd.pos_y[COORD_W-1]}}, pt_rd.pos_y};
        sz_r   <= sz_r + {{(SUM_W-COORD_W){pt_rd.pos_z[COORD_W-1]}}, pt_rd.pos_z};
        cnt_r  <= cnt_r + 1'b1;
        if (pt_rd.red > rmax_r)   rmax_r <= pt_rd.red;
        if (pt_rd.green > gmax_r) gmax_r <= pt_rd.green;
      end
    end
    if (cmd.res_cap) begin
      res_red_r   <= rmax_r;
      res_green_r <= gmax_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_r            <= '0;
      out_r.valid_res  <= cmd.out_valid;
      out_r.last_voxel <= cmd.out_last;
      out_r.dropped    <= ovf_r;
      if (cmd.out_valid) begin
        out_r.cent_x    <= cent_x_r;
        out_r.cent_y    <= cent_y_r;
        out_r.cent_z    <= cent_z_r;
        out_r.red_max   <= res_red_r;
        out_r.green_max <= res_green_r;
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  assign sts.full     = count_r == CNT_W'(MAX_POINTS);
  assign sts.idx_end  = idx_r == count_r;
  assign sts.found    = found_r;
  assign sts.qual     = cnt_r >= min_points;
  assign sts.div_done = div_done;

endmodule

FILE: sv/vgd_ctrl.sv
// ----------------------------------------------------------------------------
// vgd_ctrl
// Controller: push handling, cell pass, scan passes and result sequencing.
// ----------------------------------------------------------------------------
module vgd_ctrl import vgd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic operation,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CCHK = 4'd1;
  localparam logic [3:0] ST_CRD  = 4'd2;
  localparam logic [3:0] ST_CDX  = 4'd3;
  localparam logic [3:0] ST_CDY  = 4'd4;
  localparam logic [3:0] ST_CDZ  = 4'd5;
  localparam logic [3:0] ST_CWR  = 4'd6;
  localparam logic [3:0] ST_SCHK = 4'd7;
  localparam logic [3:0] ST_SACC = 4'd8;
  localparam logic [3:0] ST_DEC  = 4'd9;
  localparam logic [3:0] ST_DCX  = 4'd10;
  localparam logic [3:0] ST_DCY  = 4'd11;
  localparam logic [3:0] ST_DCZ  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       emitting_r, emitting_nxt;
  logic       look_r, look_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      emitting_r <= 1'b0;
      look_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emitting_r <= emitting_nxt;
      look_r     <= look_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    emitting_nxt = emitting_r;
    look_nxt     = look_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_PUSH) begin
            if (emitting_r || sts.full) cmd.ovf_set = 1'b1;
            else                        cmd.push_wr = 1'b1;
          end else begin
            look_nxt    = 1'b0;
            cmd.idx_clr = 1'b1;
            if (emitting_r) begin
              cmd.acc_clr = 1'b1;
              state_nxt   = ST_SCHK;
            end else begin
              cmd.bound_clr = 1'b1;
              state_nxt     = ST_CCHK;
            end
          end
        end
      end
      ST_CCHK: begin
        if (sts.idx_end) begin
          emitting_nxt = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.acc_clr  = 1'b1;
          state_nxt    = ST_SCHK;
        end else begin
          state_nxt = ST_CRD;
        end
      end
      ST_CRD: begin
        cmd.div_start = 1'b1;
        cmd.div_axis  = AX_X;
        state_nxt     = ST_CDX;
      end
      ST_CDX: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_axis  = AX_Y;
          state_nxt     = ST_CDY;
        end
      end
      ST_CDY: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_axis  = AX_Z;
          state_nxt     = ST_CDZ;
        end
      end
      ST_CDZ: begin
        if (sts.div_done) state_nxt = ST_CWR;
      end
      ST_CWR: begin
        cmd.key_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_CCHK;
      end
      ST_SCHK: begin
        state_nxt = sts.idx_end ? ST_DEC : ST_SACC;
      end
      ST_SACC: begin
        cmd.acc_en  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_SCHK;
      end
      ST_DEC: begin
        if (!sts.found) begin
          cmd.out_fire  = 1'b1;
          cmd.out_valid = look_r;
          cmd.out_last  = look_r;
          cmd.clr_store = 1'b1;
          emitting_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!sts.qual) begin
          cmd.bound_strict = 1'b1;
          cmd.idx_clr      = 1'b1;
          cmd.acc_clr      = 1'b1;
          state_nxt        = ST_SCHK;
        end else if (look_r) begin
          cmd.bound_incl = 1'b1;
          cmd.out_fire   = 1'b1;
          cmd.out_valid  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.res_cap   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_cent  = 1'b1;
          cmd.div_axis  = AX_X;
          state_nxt     = ST_DCX;
        end
      end
      ST_DCX: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_cent  = 1'b1;
          cmd.div_axis  = AX_Y;
          state_nxt     = ST_DCY;
        end
      end
      ST_DCY: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_cent  = 1'b1;
          cmd.div_axis  = AX_Z;
          state_nxt     = ST_DCZ;
        end
      end
      ST_DCZ: begin
        if (sts.div_done) begin
          cmd.bound_strict = 1'b1;
          cmd.idx_clr      = 1'b1;
          cmd.acc_clr      = 1'b1;
          look_nxt         = 1'b1;
          state_nxt        = ST_SCHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = state_r != ST_IDLE;

endmodule

FILE: sv/voxel_grid_downsample.sv
// ----------------------------------------------------------------------------
// voxel_grid_downsample
// Point store with voxel-grid grouping; returns one voxel centroid or empty word per pull.
// ----------------------------------------------------------------------------
//
//  channel   ports                           handshake
//  --------  ------------------------------  ---------------------------------
//  input     start, busy, in_item            taken when start && !busy
//  result    out_strobe, out_item            one-cycle strobe, always taken
//  config    cfg_valid, cfg_ready,           taken when cfg_valid && cfg_ready
//            cfg_index, cfg_data
//
//  A push word is a plain write into the point store, so pushes stream back
//  to back. The first pull after loading runs a cell pass over every stored
//  point through the shared serial divider, one divide per axis. Every pull
//  then scans the store once per candidate voxel and divides the centroid of
//  the voxel it finds; the result word is on the ports in the first cycle that
//  busy is low. Reset is synchronous and needs no clearing pass. The receiver
//  cannot stall, so no result word is held back.
//
//  Voxels are found by scanning for the smallest cell key above a bound and
//  folding all points of that key in one pass; a second scan looks ahead to
//  flag the last voxel and to leave the bound on the next one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_grid_downsample import vgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  // result words
  output logic                 out_strobe,
  output out_item_t            out_item,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DVS_W-1:0]     cfg_data
);

  logic [DVS_W-1:0]  leaf_r;
  logic [MINP_W-1:0] minp_r;
  cmd_t              cmd;
  sts_t              sts;

  // configuration writes land at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_r <= LEAF_RESET;
      minp_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEAF: leaf_r <= cfg_data;
        REG_MINP: minp_r <= cfg_data[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence pushes, cell pass, scans and result hand-off
  vgd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .operation(in_item.operation),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  // hold stores, accumulate, divide and drive the result word
  vgd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .leaf_size (leaf_r),
    .min_points(minp_r),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  `ASSERT_IMP(a_out_when_idle, out_strobe, !busy)
  `ASSERT_NXT(a_pull_goes_busy, start && !busy && in_item.operation == OP_PULL, busy)
  `ASSERT_NXT(a_push_no_result, start && !busy && in_item.operation == OP_PUSH, !out_strobe)
  `ASSERT_IMP(a_empty_is_zero, out_strobe && !out_item.valid_res, out_item.red_max == '0)

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voxel_grid_downsample. A short table of directed
// words runs first, then randomised clouds of clustered points are loaded and
// drained voxel by voxel under random idling and register changes. Every
// result word is checked field by field against a voxel predictor held
// inside the bench, or against a typed directed row's own expected word.
// ----------------------------------------------------------------------------
module tb;
  import vgd_pkg::*;

  // Directed table row: a register write or an input word.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] ridx;
    logic [DVS_W-1:0]     rval;
    in_item_t             word;
    bit                   typed;
    out_item_t            want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_item   = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DVS_W-1:0]     cfg_data  = '0;

  voxel_grid_downsample dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Voxel predictor state: its own copy of the registers and the point store.
  // --------------------------------------------------------------------------
  int unsigned vox_leaf = 32'(LEAF_RESET);
  int unsigned vox_minp = 0;
  in_item_t    vox_pts [MAX_POINTS];
  int          cell_x [MAX_POINTS];
  int          cell_y [MAX_POINTS];
  int          cell_z [MAX_POINTS];
  int          cell_order[$];
  int          grp_lo[$];
  int          grp_n[$];
  int          vox_count    = 0;
  int          vox_gcur     = 0;
  bit          vox_emitting = 1'b0;
  bit          vox_ovf      = 1'b0;

  out_item_t   voxel_q[$];     // expected result words, oldest first
  int          mismatches = 0;
  int          items_sent = 0;
  bit          fast_mode  = 1'b0;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic bit cell_before(int a, int b);
    if (cell_z[a] != cell_z[b]) return cell_z[a] < cell_z[b];
    if (cell_y[a] != cell_y[b]) return cell_y[a] < cell_y[b];
    return cell_x[a] < cell_x[b];
  endfunction

  function automatic bit cell_equal(int a, int b);
    return cell_x[a] == cell_x[b] && cell_y[a] == cell_y[b] && cell_z[a] == cell_z[b];
  endfunction

  // Bin every stored point into its cell and group the points cell by cell.
  task automatic bin_points();
    longint leaf;
    int     j;
    leaf = (vox_leaf == 0) ? 1 : longint'(vox_leaf);
    cell_order.delete();
    grp_lo.delete();
    grp_n.delete();
    for (int i = 0; i < vox_count; i++) begin
      cell_x[i] = int'(floor_div(longint'($signed(vox_pts[i].pos_x)), leaf));
      cell_y[i] = int'(floor_div(longint'($signed(vox_pts[i].pos_y)), leaf));
      cell_z[i] = int'(floor_div(longint'($signed(vox_pts[i].pos_z)), leaf));
      j = cell_order.size();
      while (j > 0 && cell_before(i, cell_order[j-1])) j--;
      cell_order.insert(j, i);
    end
    for (int k = 0; k < vox_count; k++) begin
      if (k == 0 || !cell_equal(cell_order[k], cell_order[k-1])) begin
        grp_lo.insert(grp_lo.size(), k);
        grp_n.insert(grp_n.size(), 1);
      end else begin
        grp_n[grp_n.size()-1]++;
      end
    end
  endtask

  function automatic int next_kept_group(int from);
    while (from < grp_lo.size() && grp_n[from] < vox_minp) from++;
    return from;
  endfunction

  task automatic clear_points();
    vox_count    = 0;
    vox_gcur     = 0;
    vox_emitting = 1'b0;
    vox_ovf      = 1'b0;
  endtask

  // Advance the predictor by one accepted word; a pull yields a voxel word.
  task automatic predict_voxel(input in_item_t w, output bit has_res, output out_item_t r);
    int     g;
    int     p;
    longint sx, sy, sz;
    r       = '0;
    has_res = 1'b0;
    sx = 0; sy = 0; sz = 0;
    if (w.operation == OP_PUSH) begin
      if (vox_emitting || vox_count >= MAX_POINTS) begin
        vox_ovf = 1'b1;
      end else begin
        vox_pts[vox_count] = w;
        vox_count++;
      end
      return;
    end
    has_res = 1'b1;
    if (!vox_emitting) begin
      bin_points();
      vox_emitting = 1'b1;
      vox_gcur     = 0;
    end
    g = next_kept_group(vox_gcur);
    if (g >= grp_lo.size()) begin
      r.dropped = vox_ovf;
      clear_points();
      return;
    end
    for (int k = grp_lo[g]; k < grp_lo[g] + grp_n[g]; k++) begin
      p = cell_order[k];
      sx += $signed(vox_pts[p].pos_x);
      sy += $signed(vox_pts[p].pos_y);
      sz += $signed(vox_pts[p].pos_z);
      if (vox_pts[p].red > r.red_max)     r.red_max   = vox_pts[p].red;
      if (vox_pts[p].green > r.green_max) r.green_max = vox_pts[p].green;
    end
    r.valid_res  = 1'b1;
    r.cent_x     = COORD_W'(floor_div(sx, grp_n[g]));
    r.cent_y     = COORD_W'(floor_div(sy, grp_n[g]));
    r.cent_z     = COORD_W'(floor_div(sz, grp_n[g]));
    r.dropped    = vox_ovf;
    vox_gcur     = next_kept_group(g + 1);
    r.last_voxel = (vox_gcur >= grp_lo.size());
    if (r.last_voxel) clear_points();
  endtask

  // --------------------------------------------------------------------------
  // Result side: every strobed word is taken and matched to the oldest
  // expectation. Sample at the edge, before the block updates.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_strobe) begin
      if (voxel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
      end else begin
        e = voxel_q.pop_front();
        check_field("valid_res",  e.valid_res,          out_item.valid_res);
        check_field("cent_x",     $signed(e.cent_x),    $signed(out_item.cent_x));
        check_field("cent_y",     $signed(e.cent_y),    $signed(out_item.cent_y));
        check_field("cent_z",     $signed(e.cent_z),    $signed(out_item.cent_z));
        check_field("red_max",    e.red_max,            out_item.red_max);
        check_field("green_max",  e.green_max,          out_item.green_max);
        check_field("last_voxel", e.last_voxel,         out_item.last_voxel);
        check_field("dropped",    e.dropped,            out_item.dropped);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (fast_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Offer a word, hold it until taken, then idle for the chosen gap. With no
  // gap, start stays high so the next word follows back to back.
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t want);
    bit        has_res;
    out_item_t r;
    int        gap;
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_voxel(w, has_res, r);
    if (has_res) voxel_q.insert(voxel_q.size(), typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold until every expected word is in and the block rests.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (voxel_q.size() != 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DVS_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_LEAF) vox_leaf = 32'(val);
    else                 vox_minp = 32'(val & 16'h1FFF);
  endtask

  function automatic in_item_t push_word(int x, int y, int z, int r, int g);
    in_item_t w;
    w.operation = OP_PUSH;
    w.pos_x     = COORD_W'(x);
    w.pos_y     = COORD_W'(y);
    w.pos_z     = COORD_W'(z);
    w.red       = COL_W'(r);
    w.green     = COL_W'(g);
    return w;
  endfunction

  // A pull carries random bits in the unused fields.
  function automatic in_item_t pull_word();
    in_item_t w;
    w.operation = OP_PULL;
    w.pos_x     = COORD_W'($urandom);
    w.pos_y     = COORD_W'($urandom);
    w.pos_z     = COORD_W'($urandom);
    w.red       = COL_W'($urandom);
    w.green     = COL_W'($urandom);
    return w;
  endfunction

  function automatic out_item_t voxel_word(int x, int y, int z, int r, int g);
    out_item_t o;
    o            = '0;
    o.valid_res  = 1'b1;
    o.cent_x     = COORD_W'(x);
    o.cent_y     = COORD_W'(y);
    o.cent_z     = COORD_W'(z);
    o.red_max    = COL_W'(r);
    o.green_max  = COL_W'(g);
    o.last_voxel = 1'b1;
    return o;
  endfunction

  function automatic int pick_leaf();
    case ($urandom_range(0, 6))
      0:       return 1;
      1:       return 65535;
      2:       return 0;
      3:       return $urandom_range(2, 16);
      4:       return $urandom_range(50, 500);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_minp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5:       return 1;
      6, 7:       return $urandom_range(2, 4);
      8:          return 4096;
      default:    return $urandom_range(0, 4096);
    endcase
  endfunction

  // Load one cloud: points gather around a few centres so cells fill up,
  // with the odd point anywhere in the coordinate range.
  task automatic load_cloud();
    int        npts, ncent, spread, c;
    int        cx[4], cy[4], cz[4];
    out_item_t none;
    none   = '0;
    npts   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    ncent  = $urandom_range(1, 4);
    spread = $urandom_range(0, 2 * ((vox_leaf == 0) ? 1 : vox_leaf));
    for (int k = 0; k < ncent; k++) begin
      cx[k] = int'($signed(24'($urandom)));
      cy[k] = int'($signed(24'($urandom)));
      cz[k] = int'($signed(24'($urandom)));
    end
    for (int i = 0; i < npts; i++) begin
      c = $urandom_range(0, ncent - 1);
      if ($urandom_range(0, 9) == 0)
        send_word(push_word($urandom, $urandom, $urandom, $urandom, $urandom), 1'b0, none);
      else
        send_word(push_word(int'(cx[c] + $urandom_range(0, spread) - spread / 2),
                            int'(cy[c] + $urandom_range(0, spread) - spread / 2),
                            int'(cz[c] + $urandom_range(0, spread) - spread / 2),
                            $urandom, $urandom), 1'b0, none);
      items_sent++;
    end
  endtask

  // Drain the loaded cloud; now and then push into it, which is lost, or retune mid-way.
  task automatic drain_cloud();
    out_item_t none;
    none = '0;
    do begin
      send_word(pull_word(), 1'b0, none);
      items_sent++;
      if (vox_emitting && $urandom_range(0, 7) == 0) begin
        send_word(push_word($urandom, $urandom, $urandom, $urandom, $urandom), 1'b0, none);
        items_sent++;
      end
      if (vox_emitting && $urandom_range(0, 9) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_MINP : REG_LEAF,
                  DVS_W'(($urandom_range(0, 1) == 0) ? pick_minp() : pick_leaf()));
    end while (vox_emitting);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  task automatic add_row(input bit is_cfg, input logic [CFG_IDX_W-1:0] idx, input int val,
                         input in_item_t w, input bit typed, input out_item_t want);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.ridx   = idx;
    row.rval   = DVS_W'(val);
    row.word   = w;
    row.typed  = typed;
    row.want   = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("voxel_grid_downsample test failed");
    $finish;
  end

  initial begin
    out_item_t none;
    out_item_t blank;
    none  = '0;
    blank = '0;

    // Empty store, extreme corners, a shared cell and a negative cell.
    add_row(0, REG_LEAF, 0, pull_word(), 1, blank);
    add_row(0, REG_LEAF, 0, push_word(8388607, 8388607, 8388607, 255, 255), 0, none);
    add_row(0, REG_LEAF, 0, push_word(-8388608, -8388608, -8388608, 0, 0), 0, none);
    add_row(0, REG_LEAF, 0, push_word(0, 0, 0, 1, 2), 0, none);
    add_row(0, REG_LEAF, 0, push_word(101, 101, 101, 128, 64), 0, none);
    add_row(0, REG_LEAF, 0, push_word(-1, 0, 0, 3, 4), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 0, none);
    // a push during the drain is lost and flagged on later words
    add_row(0, REG_LEAF, 0, push_word(1, 1, 1, 9, 9), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 0, none);
    // zero leaf behaves as a leaf of one
    add_row(1, REG_LEAF, 0, none, 0, none);
    add_row(0, REG_LEAF, 0, push_word(-3, -3, -3, 0, 255), 0, none);
    add_row(0, REG_LEAF, 0, push_word(-3, -3, -3, 255, 0), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 1, voxel_word(-3, -3, -3, 255, 255));
    add_row(1, REG_LEAF, 65535, none, 0, none);
    add_row(0, REG_LEAF, 0, push_word(5, 5, 5, 7, 9), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 1, voxel_word(5, 5, 5, 7, 9));
    // nothing reaches the minimum: an empty word and a cleared store
    add_row(1, REG_MINP, 4096, none, 0, none);
    add_row(0, REG_LEAF, 0, push_word(1, 2, 3, 4, 5), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 1, blank);
    // a lone point is skipped, the pair in the next cell is kept
    add_row(1, REG_MINP, 2, none, 0, none);
    add_row(0, REG_LEAF, 0, push_word(0, 0, 0, 1, 1), 0, none);
    add_row(0, REG_LEAF, 0, push_word(70000, 0, 0, 2, 2), 0, none);
    add_row(0, REG_LEAF, 0, push_word(70001, 0, 0, 3, 3), 0, none);
    add_row(0, REG_LEAF, 0, pull_word(), 1, voxel_word(70000, 0, 0, 3, 3));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].ridx, dir_rows[i].rval);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        items_sent++;
      end
    end

    // Random clouds until enough words have gone in.
    while (items_sent < 720) begin
      fast_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) write_reg(REG_LEAF, DVS_W'(pick_leaf()));
      if ($urandom_range(0, 3) == 0) write_reg(REG_MINP, DVS_W'(pick_minp()));
      load_cloud();
      drain_cloud();
      if ($urandom_range(0, 5) == 0) begin
        send_word(pull_word(), 1'b0, none);
        items_sent++;
      end
      // hold the sender until the block has answered everything
      if ($urandom_range(0, 4) == 0) wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && voxel_q.size() == 0) begin
      $display("voxel_grid_downsample test passed");
    end else begin
      $display("voxel_grid_downsample test failed");
    end
    $finish;
  end

endmodule
